>>> hw/rtl/tdpt_pkg.sv
// tdpt_pkg: shared types, sequencer codes and first divisor constants for the trial division prime tester
// depends on nothing; imported by trial_division_prime_test

package tdpt_pkg;

   // sequencer state
   typedef logic [2:0] state_type;

   localparam state_type ST_IDLE   = 3'd0;
   localparam state_type ST_CHECK  = 3'd1;
   localparam state_type ST_DIV    = 3'd2;
   localparam state_type ST_NEXT   = 3'd3;
   localparam state_type ST_FINISH = 3'd4;

   // first trial divisor and its square
   localparam int unsigned FIRST_DIVISOR = 2;
   localparam int unsigned FIRST_SQUARE  = 4;

endpackage

>>> hw/rtl/trial_division_prime_test.sv
// trial_division_prime_test: one-item-at-a-time primality test by trial division
// depends on tdpt_pkg (state codes, first divisor constants)
//
// candidates below 2 go from idle straight to the finish state; otherwise each
//   trial divisor passes through the check, divide and next states, divisors
//   running from 2 up to floor(sqrt(candidate)) or the first exact divisor
// one item at a time: a new candidate is taken only in the idle state; the
//   single restoring divider (one remainder bit per cycle) does the divisions
// reset: synchronous, active high; clears the sequencer and the result valid

module trial_division_prime_test
   import tdpt_pkg::*;
#(
   parameter int NUMBER_WIDTH = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   // input item
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [NUMBER_WIDTH-1:0] req_candidate,
   // result item
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_is_prime
);

   // divisor width: covers sqrt of the largest candidate plus headroom
   localparam int DW = NUMBER_WIDTH / 2 + 2;
   // remainder width: one bit more than the divisor for the trial subtract
   localparam int RW = DW + 1;
   // square width: (d+1)^2 may just pass the largest candidate
   localparam int SW = NUMBER_WIDTH + 2;
   // bit counter for the restoring divider
   localparam int CW = $clog2(NUMBER_WIDTH);
   localparam logic [CW-1:0] LAST_BIT = CW'(NUMBER_WIDTH - 1);

   // sequencer
   state_type state_ff, state_in;

   // operands held for the whole item
   logic [NUMBER_WIDTH-1:0] num_ff,   num_in;    // candidate under test
   logic [DW-1:0]           d_ff,     d_in;      // current trial divisor
   logic [SW-1:0]           sq_ff,    sq_in;     // d_ff squared, kept by adding 2d+1

   // restoring divider
   logic [NUMBER_WIDTH-1:0] shift_ff, shift_in;  // dividend bits still to bring down
   logic [RW-1:0]           rem_ff,   rem_in;    // partial remainder
   logic [CW-1:0]           cnt_ff,   cnt_in;    // bits left minus one

   // finished verdict waiting for the output register
   logic                    verdict_ff, verdict_in;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_prime_ff, rsp_prime_in;

   // divider datapath: shift in the next dividend bit and try to subtract
   logic [RW-1:0] rem_shifted;
   logic [RW:0]   trial_diff;
   logic          out_free;

   assign rem_shifted = {rem_ff[RW-2:0], shift_ff[NUMBER_WIDTH-1]};
   assign trial_diff  = {1'b0, rem_shifted} - {2'b00, d_ff};
   assign out_free    = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      num_in       = num_ff;
      d_in         = d_ff;
      sq_in        = sq_ff;
      shift_in     = shift_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      verdict_in   = verdict_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_prime_in = rsp_prime_ff;

      // result taken by the receiver
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               num_in = req_candidate;
               d_in   = DW'(FIRST_DIVISOR);
               sq_in  = SW'(FIRST_SQUARE);
               // zero and one are never prime
               if (req_candidate < NUMBER_WIDTH'(2)) begin
                  verdict_in = 1'b0;
                  state_in   = ST_FINISH;
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            // past the square root with no exact divisor: prime
            if (sq_ff > {2'b00, num_ff}) begin
               verdict_in = 1'b1;
               state_in   = ST_FINISH;
            end else begin
               shift_in = num_ff;
               rem_in   = '0;
               cnt_in   = LAST_BIT;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            // one remainder bit a cycle
            shift_in = {shift_ff[NUMBER_WIDTH-2:0], 1'b0};
            if (!trial_diff[RW]) begin
               rem_in = trial_diff[RW-1:0];
            end else begin
               rem_in = rem_shifted;
            end
            if (cnt_ff == '0) begin
               state_in = ST_NEXT;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_NEXT: begin
            if (rem_ff == '0) begin
               // exact divisor found: composite
               verdict_in = 1'b0;
               state_in   = ST_FINISH;
            end else begin
               // (d+1)^2 = d^2 + 2d + 1
               sq_in    = sq_ff + {{(SW-DW-1){1'b0}}, d_ff, 1'b1};
               d_in     = d_ff + 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_FINISH: begin
            // hand over once the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_prime_in = verdict_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath, no reset needed
   always_ff @(posedge clock) begin
      num_ff       <= num_in;
      d_ff         <= d_in;
      sq_ff        <= sq_in;
      shift_ff     <= shift_in;
      rem_ff       <= rem_in;
      cnt_ff       <= cnt_in;
      verdict_ff   <= verdict_in;
      rsp_prime_ff <= rsp_prime_in;
   end

   // a new item is taken only while the sequencer is idle
   assign req_stall    = (state_ff != ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_is_prime = rsp_prime_ff;

   // partial remainder always stays below the divisor
   a_rem_below_divisor : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < {1'b0, d_ff}))
      else $error("partial remainder not below trial divisor");

   // trial divisor never drops below two while dividing
   a_divisor_at_least_two : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (d_ff >= DW'(FIRST_DIVISOR)))
      else $error("trial divisor below two");

   // a prime verdict needs a candidate of at least two
   a_prime_needs_two : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && verdict_ff) |-> (num_ff >= NUMBER_WIDTH'(2)))
      else $error("prime verdict on zero or one");

   // the divisor only moves on after a non-zero remainder
   a_step_after_nonzero : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_NEXT && rem_ff == '0) |=> (state_ff == ST_FINISH && !verdict_ff))
      else $error("exact divisor not reported as composite");

   // a finished result is never dropped while the output is held
   a_result_waits : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && !out_free) |=> (state_ff == ST_FINISH))
      else $error("finished item left while output register busy");

endmodule

>>> tb/testbench.sv
// testbench: self-checking bench for trial_division_prime_test
// depends on the rtl top level only; directed table first, then random candidates
// each accepted result is checked against its typed-in flag or a local trial-division predictor

`timescale 1ns / 1ps

module testbench;

   localparam int NUMBER_WIDTH = 16;
   localparam int PROBE_ROWS   = 22;
   localparam int RANDOM_ITEMS = 118;
   // the long receiver hold starts once this many items have gone in
   localparam int HOLD_AFTER   = 30;
   // long enough for two slowest items to finish behind a held result
   localparam int HOLD_CYCLES  = 10000;
   localparam int REPORT_LIMIT = 10;

   // one row of the directed table; where given is set the flag is typed in
   typedef struct packed {
      logic [NUMBER_WIDTH-1:0] candidate;
      bit                      given;
      bit                      flag;
   } probe_row_type;

   // what one result item should carry, with the candidate kept for reports
   typedef struct packed {
      logic [NUMBER_WIDTH-1:0] candidate;
      logic                    is_prime;
   } verdict_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [NUMBER_WIDTH-1:0] req_candidate = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic                    rsp_is_prime;

   verdict_type expected_verdicts [$];
   int unsigned items_accepted = 0;
   int unsigned fail_count = 0;

   // directed cases: below two, the first primes, squares of primes (the
   // divisor bound is hit exactly), the largest 16-bit prime, both
   // alternating bit patterns and the top of the range
   probe_row_type probe_table [PROBE_ROWS] = '{
      '{16'd0,     1'b1, 1'b0},   // zero is not prime
      '{16'd1,     1'b1, 1'b0},   // one is not prime
      '{16'd2,     1'b1, 1'b1},   // two: no divisor is tried
      '{16'd3,     1'b1, 1'b1},
      '{16'd4,     1'b1, 1'b0},
      '{16'd5,     1'b0, 1'b0},
      '{16'd9,     1'b0, 1'b0},
      '{16'd25,    1'b0, 1'b0},
      '{16'd49,    1'b0, 1'b0},
      '{16'd97,    1'b0, 1'b0},
      '{16'd251,   1'b0, 1'b0},
      '{16'd253,   1'b0, 1'b0},
      '{16'd257,   1'b0, 1'b0},
      '{16'd961,   1'b0, 1'b0},
      '{16'd4093,  1'b0, 1'b0},
      '{16'd32767, 1'b0, 1'b0},
      '{16'd32768, 1'b1, 1'b0},   // top bit alone, even
      '{16'd43690, 1'b1, 1'b0},   // 1010... pattern, even
      '{16'd21845, 1'b0, 1'b0},   // 0101... pattern
      '{16'd65025, 1'b0, 1'b0},   // 255 squared
      '{16'd65521, 1'b0, 1'b0},   // largest prime below 2^16, slowest case
      '{16'd65535, 1'b0, 1'b0}    // all ones
   };

   trial_division_prime_test #(
      .NUMBER_WIDTH (NUMBER_WIDTH)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_candidate (req_candidate),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_is_prime  (rsp_is_prime)
   );

   // 8 ns clock period
   always #4 clock = ~clock;

   // reset held at the start, never again
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   // prime when at least two and no divisor up to the square root divides it
   function automatic logic is_prime_by_division(input logic [NUMBER_WIDTH-1:0] n);
      int unsigned value;
      value = 32'(n);
      if (value < 2) return 1'b0;
      for (int unsigned d = 2; d * d <= value; d++) begin
         if (value % d == 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   // idle length: mostly none or a few cycles, now and then a long one
   function automatic int unsigned idle_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      else if (roll < 90) return $urandom_range(1, 3);
      else if (roll < 97) return $urandom_range(4, 20);
      else return $urandom_range(30, 150);
   endfunction

   // mostly small numbers keep the search short; a share of full-range
   // values and products of two factors reach the deep end of the search
   function automatic logic [NUMBER_WIDTH-1:0] random_candidate();
      int unsigned roll;
      int unsigned a;
      int unsigned b;
      roll = $urandom_range(0, 99);
      if (roll < 40) return NUMBER_WIDTH'($urandom_range(0, 255));
      else if (roll < 70) return NUMBER_WIDTH'($urandom_range(0, 4095));
      else if (roll < 85) return NUMBER_WIDTH'($urandom_range(0, 65535));
      else begin
         a = $urandom_range(2, 255);
         b = $urandom_range(2, 255);
         return NUMBER_WIDTH'(a * b);
      end
   endfunction

   // offer one item, wait for the handshake, log what it must produce,
   // then idle a while; valid stays high when there is no gap
   task automatic offer_candidate(input logic [NUMBER_WIDTH-1:0] n,
                                  input bit given, input bit given_flag);
      verdict_type v;
      int unsigned gap;
      req_valid     <= 1'b1;
      req_candidate <= n;
      do @(posedge clock); while (req_stall);
      v.candidate = n;
      v.is_prime  = given ? given_flag : is_prime_by_division(n);
      expected_verdicts.insert(expected_verdicts.size(), v);
      items_accepted++;
      gap = idle_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // sender: directed table, then the random items, then drain and report
   initial begin : drive_candidates
      @(posedge clock);
      while (reset) @(posedge clock);
      for (int i = 0; i < PROBE_ROWS; i++) begin
         offer_candidate(probe_table[i].candidate, probe_table[i].given,
                         probe_table[i].flag);
      end
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         offer_candidate(random_candidate(), 1'b0, 1'b0);
      end
      req_valid <= 1'b0;
      // every result in, then a quiet spell to catch any stray result
      while (expected_verdicts.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // receiver back-pressure: random stalls between stall-free stretches,
   // plus one long hold so the block fills and stalls its own input
   int unsigned stall_left = 0;
   int unsigned free_left = 0;
   bit          hold_done = 1'b0;

   always @(posedge clock) begin
      if (!reset && !hold_done && items_accepted >= HOLD_AFTER) begin
         hold_done  <= 1'b1;
         stall_left <= HOLD_CYCLES - 1;
         free_left  <= 0;
         rsp_stall  <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if (free_left != 0) begin
         free_left <= free_left - 1;
         rsp_stall <= 1'b0;
      end else begin
         // pick the next stall and the free stretch that follows it
         stall_left <= idle_gap();
         free_left  <= $urandom_range(1, 40);
         rsp_stall  <= 1'b0;
      end
   end

   // result check: each accepted result against the oldest expectation
   always @(posedge clock) begin : check_verdicts
      verdict_type v;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_verdicts.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
               $display("%0t: result item with nothing pending, is_prime=%0b",
                        $realtime, rsp_is_prime);
         end else begin
            v = expected_verdicts.pop_front();
            if (rsp_is_prime !== v.is_prime) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("%0t: candidate %0d is_prime expected %0b got %0b",
                           $realtime, v.candidate, v.is_prime, rsp_is_prime);
            end
         end
      end
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #40_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
